// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the bit packer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside of reset.
`define EGBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check on every clock edge, reset cycles included.
`define EGBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/egbp_pkg.sv =====
// ----------------------------------------------------------------------------
// egbp_pkg
// Types and constants shared by the bit packer, its channels and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package egbp_pkg;

    // Output word size; the datapath is sized for this value.
    localparam int WORD_BITS   = 32;
    // Input field widths.
    localparam int KIND_W      = 2;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 6;
    // Fill level of the open word, 0..WORD_BITS.
    localparam int FILL_W      = 6;
    // Length of one code in bits: up to 64 (unary with 63 zeros).
    localparam int LEN_W       = 7;
    // Open word plus the longest code, left aligned.
    localparam int STREAM_BITS = 3 * WORD_BITS;
    // Words in the stream; one code item can complete at most two of them.
    localparam int MAX_WORDS   = 3;
    localparam int NWORDS_W    = 2;

    localparam logic [WORD_BITS-1:0] ALL_ONES = {WORD_BITS{1'b1}};

    typedef enum logic [KIND_W-1:0] {
        KIND_RAW   = 2'd0,
        KIND_UNARY = 2'd1,
        KIND_GAMMA = 2'd2,
        KIND_FLUSH = 2'd3
    } t_kind;

endpackage

`default_nettype wire

// ===== rtl/egbp_in_if.sv =====
// ----------------------------------------------------------------------------
// egbp_in_if
// Input channel of the bit packer: one code item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface egbp_in_if;
    logic                          valid;
    logic                          ready;
    logic [egbp_pkg::KIND_W-1:0]   kind;
    logic [egbp_pkg::VALUE_W-1:0]  value;
    logic [egbp_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output kind, output value, output count, input ready);
    modport sink   (input valid, input kind, input value, input count, output ready);
endinterface

`default_nettype wire

// ===== rtl/egbp_out_if.sv =====
// ----------------------------------------------------------------------------
// egbp_out_if
// Output channel of the bit packer: one packed word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface egbp_out_if;
    logic                            valid;
    logic                            ready;
    logic [egbp_pkg::WORD_BITS-1:0]  packed_word;
    logic                            last_of_run;

    modport source (output valid, output packed_word, output last_of_run, input ready);
    modport sink   (input valid, input packed_word, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/elias_gamma_bit_packer.sv =====
// ----------------------------------------------------------------------------
// elias_gamma_bit_packer
// MSB-first bit packer for raw fields, unary codes and Elias-gamma codes.
//
// Each input item appends a code to an open 32-bit word, first bit at the
// top: kind 0 appends the low count bits of value (count 1..32, anything else
// is dropped), kind 1 appends count zeros and a one, kind 2 appends the gamma
// code of value (value zero is dropped), kind 3 flushes the open word left
// aligned, also when it is empty. A word that fills up is held and leaves only
// when the next bit arrives or on a flush, so one item yields zero, one or two
// words (a flush exactly one); last_of_run marks the final word of an item.
// Flow: the input stage takes an item in every cycle in which the merge stage
// is empty or retires its item; the code is formed on the way in (mask,
// leading-one search), merged with the open word by a 96-bit shift in the next
// cycle and sent through an output register. An item that completes two words
// holds the merge stage until both have gone, limited by the single output
// port, and a stalled output holds it as well.
// ----------------------------------------------------------------------------
`default_nettype none

module elias_gamma_bit_packer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    egbp_in_if.sink     i_in,
    egbp_out_if.source  o_out
);
    import egbp_pkg::*;

    typedef logic [WORD_BITS-1:0] t_word;

    // ---- input side: form the code, right aligned, and its length ----------
    t_kind                kind_in;
    logic [4:0]           msb_pos;
    logic [COUNT_W-1:0]   raw_shift;
    t_word                n_code;
    logic [LEN_W-1:0]     n_len;
    logic                 n_flush;

    // ---- merge stage registers ---------------------------------------------
    logic                 r_s_valid;
    t_word                r_code;
    logic [LEN_W-1:0]     r_len;
    logic                 r_flush;
    logic                 r_idx;

    // ---- packer state -------------------------------------------------------
    t_word                r_pw;
    logic [FILL_W-1:0]    r_fill;

    // ---- output register ----------------------------------------------------
    logic                 r_out_valid;
    t_word                r_out_word;
    logic                 r_out_last;

    // ---- merge logic --------------------------------------------------------
    logic [LEN_W-1:0]       total;
    logic [LEN_W-1:0]       total_m1;
    logic [STREAM_BITS-1:0] head;
    logic [STREAM_BITS-1:0] tail;
    logic [STREAM_BITS-1:0] stream;
    t_word                  words [MAX_WORDS];
    logic [NWORDS_W-1:0]    code_words;
    logic [NWORDS_W-1:0]    s_nwords;
    logic [FILL_W-1:0]      new_fill;
    t_word                  new_pw;
    t_word                  cur_word;
    logic                   is_last;
    logic                   out_load;
    logic                   s_emit;
    logic                   s_retire;
    logic                   in_ready;
    logic                   accept;

    assign kind_in = t_kind'(i_in.kind);

    // Leading-one position of value: e = floor(log2(value)).
    always_comb begin
        msb_pos = '0;
        for (int i = 0; i < VALUE_W; i++) begin
            if (i_in.value[i]) begin
                msb_pos = 5'(i);
            end
        end
    end

    assign raw_shift = COUNT_W'(WORD_BITS) - i_in.count;

    always_comb begin
        n_code  = '0;
        n_len   = '0;
        n_flush = 1'b0;
        unique case (kind_in)
            KIND_RAW: begin
                // Drop out-of-range counts; clear bits above count.
                if (i_in.count != '0 && i_in.count <= COUNT_W'(WORD_BITS)) begin
                    n_code = i_in.value & (ALL_ONES >> raw_shift);
                    n_len  = LEN_W'(i_in.count);
                end
            end
            KIND_UNARY: begin
                n_code = t_word'(1);
                n_len  = LEN_W'(i_in.count) + LEN_W'(1);
            end
            KIND_GAMMA: begin
                // e zeros then the e+1 bits of value from its leading one.
                if (i_in.value != '0) begin
                    n_code = i_in.value;
                    n_len  = LEN_W'({msb_pos, 1'b1});
                end
            end
            KIND_FLUSH: begin
                n_flush = 1'b1;
            end
            default: begin
                n_flush = 1'b0;
            end
        endcase
    end

    // Open word and code placed back to back, left aligned in the stream.
    assign total    = LEN_W'(r_fill) + r_len;
    assign total_m1 = total - LEN_W'(1);
    assign head     = {r_pw, {(STREAM_BITS - WORD_BITS){1'b0}}}
                      << (LEN_W'(WORD_BITS) - LEN_W'(r_fill));
    assign tail     = {{(STREAM_BITS - WORD_BITS){1'b0}}, r_code}
                      << (LEN_W'(STREAM_BITS) - total);
    assign stream   = head | tail;

    always_comb begin
        for (int j = 0; j < MAX_WORDS; j++) begin
            words[j] = stream[STREAM_BITS - 1 - j * WORD_BITS -: WORD_BITS];
        end
    end

    // Full words before the last, still open one; a flush sends word 0 as is.
    assign code_words = NWORDS_W'(total_m1 / WORD_BITS);
    always_comb begin
        priority if (r_flush) begin
            s_nwords = NWORDS_W'(1);
        end else if (r_len == '0) begin
            s_nwords = '0;
        end else begin
            s_nwords = code_words;
        end
    end

    assign new_fill = FILL_W'(total - LEN_W'(code_words) * LEN_W'(WORD_BITS));
    assign new_pw   = words[code_words] >> (FILL_W'(WORD_BITS) - new_fill);

    assign cur_word = words[NWORDS_W'(r_idx)];
    assign is_last  = (NWORDS_W'(r_idx) + NWORDS_W'(1)) == s_nwords;

    // Handshake: the output register refills when empty or being drained.
    assign out_load = !r_out_valid || o_out.ready;
    assign s_emit   = r_s_valid && (s_nwords != '0) && out_load;
    assign s_retire = r_s_valid && ((s_nwords == '0) || (out_load && is_last));
    assign in_ready = !r_s_valid || s_retire;
    assign accept   = i_in.valid && in_ready;

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.packed_word = r_out_word;
    assign o_out.last_of_run = r_out_last;

    // Control and packer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid   <= 1'b0;
            r_idx       <= 1'b0;
            r_pw        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s_valid <= 1'b1;
            end else if (s_retire) begin
                r_s_valid <= 1'b0;
            end

            if (s_retire) begin
                r_idx <= 1'b0;
                // Commit the item: reset on flush, advance on a real code.
                if (r_flush) begin
                    r_pw   <= '0;
                    r_fill <= '0;
                end else if (r_len != '0) begin
                    r_pw   <= new_pw;
                    r_fill <= new_fill;
                end
            end else if (s_emit) begin
                r_idx <= 1'b1;
            end

            if (s_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code  <= n_code;
            r_len   <= n_len;
            r_flush <= n_flush;
        end
        if (s_emit) begin
            r_out_word <= cur_word;
            r_out_last <= is_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/egbp_checker.sv =====
// ----------------------------------------------------------------------------
// egbp_checker
// Port-level checks for the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module egbp_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_ready,
    input wire                           i_out_valid,
    input wire                           i_out_ready,
    input wire [egbp_pkg::WORD_BITS-1:0] i_out_word,
    input wire                           i_out_last
);
    import egbp_pkg::*;

    // No word is left over from before reset.
    `EGBP_ASSERT_ALWAYS(a_rst_out_idle, i_clk, !i_rst_n |=> !i_out_valid, "word valid after reset")

    // The packer is ready for an item right after reset.
    `EGBP_ASSERT_ALWAYS(a_rst_in_ready, i_clk, !i_rst_n |=> i_in_ready, "not ready after reset")

    // A stalled word holds.
    `EGBP_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_word) && $stable(i_out_last), "stalled word changed")

    // The second word of an item follows the first without a gap.
    `EGBP_ASSERT(a_run_cont, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_out_last |=> i_out_valid, "run broken after non-last word")

endmodule

bind elias_gamma_bit_packer egbp_checker u_egbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_word  (o_out.packed_word),
    .i_out_last  (o_out.last_of_run)
);

`default_nettype wire
